// ===== rtl/core/asa_pkg.sv =====
package asa_pkg;

	// Default table geometry
	localparam int unsigned SLOTS_DEF    = 8;
	localparam int unsigned KEY_BITS_DEF = 16;

	// Fixed field widths on the stream ports
	localparam int unsigned OP_W     = 2;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned SPILL_W  = 32;

	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [SPILL_W-1:0] SPILL_MAX = '1;

	// Request codes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

	// Result codes
	localparam logic [STATUS_W-1:0] ST_HELD      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FREE_MISS = 3'd4;

endpackage

// ===== rtl/core/associative_slot_allocator_top.sv =====
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while the result stream is not stalled; the key compare
// across all slots and the lowest-free-slot pick are done in one pass between the two registers.
// Reset (arst_n low, asynchronous): all slots free, spill counter zero, both stages empty.
// Slot keys are not reset; a key is only compared while its slot is in use.
module associative_slot_allocator_top
	import asa_pkg::*;
#(
	parameter int unsigned SLOTS    = SLOTS_DEF,
	parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[15:0]
	input  logic [OP_W-1:0]       s_axis_tuser,   // op[1:0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot_index[2:0], spill_total[34:3], zero pad
	output logic [STATUS_W-1:0]   m_axis_tuser    // status[2:0]
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned KX_W  = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
	localparam int unsigned IX_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	// Input stage
	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [KEY_W-1:0]     key_s1;

	// Table
	logic [SLOTS-1:0]     used_q;
	logic [KEY_BITS-1:0]  slot_key_q [SLOTS];
	logic [SPILL_W-1:0]   spill_q;

	// Result stage
	logic                 valid_s2;
	logic [STATUS_W-1:0]  status_s2;
	logic [SLOT_W-1:0]    slot_s2;
	logic [SPILL_W-1:0]   spill_s2;

	logic                 advance;
	logic [KX_W-1:0]      key_ext;
	logic [KEY_BITS-1:0]  key_k;
	logic [SLOTS-1:0]     hit_vec;
	logic [SLOTS-1:0]     free_vec;
	logic [SLOTS-1:0]     hit_one;
	logic [SLOTS-1:0]     free_one;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     free_idx;
	logic                 any_hit;
	logic                 any_free;
	logic [SLOTS-1:0]     set_vec;
	logic [SLOTS-1:0]     clr_vec;
	logic                 spill_inc;
	logic [STATUS_W-1:0]  status_c;
	logic [IDX_W-1:0]     idx_c;
	logic [IX_W-1:0]      idx_ext;
	logic [SPILL_W-1:0]   spill_c;

	// Move the input stage forward when the result register is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Fit the incoming key to the table key width
	assign key_ext = KX_W'(key_s1);
	assign key_k   = key_ext[KEY_BITS-1:0];

	// Compare the key against every used slot
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = used_q[i] && (slot_key_q[i] == key_k);
		end
	end

	assign free_vec = ~used_q;
	assign any_hit  = |hit_vec;
	assign any_free = |free_vec;

	// Isolate the lowest set bit of each vector
	assign hit_one  = hit_vec & (~hit_vec + SLOTS'(1));
	assign free_one = free_vec & (~free_vec + SLOTS'(1));

	// Encode the one-hot picks
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit_one[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (free_one[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	// Decide the outcome of the request in the input stage
	always_comb begin
		status_c  = ST_MISS;
		idx_c     = '0;
		set_vec   = '0;
		clr_vec   = '0;
		spill_inc = 1'b0;
		case (op_s1)
			OP_ALLOC: begin
				if (any_hit) begin
					status_c = ST_HELD;
					idx_c    = hit_idx;
				end else if (any_free) begin
					status_c = ST_TAKEN;
					idx_c    = free_idx;
					set_vec  = free_one;
				end else begin
					spill_inc = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (any_hit) begin
					status_c = ST_FREED;
					idx_c    = hit_idx;
					clr_vec  = hit_one;
				end else begin
					status_c = ST_FREE_MISS;
				end
			end
			default: begin
				if (any_hit) begin
					status_c = ST_HELD;
					idx_c    = hit_idx;
				end
			end
		endcase
	end

	assign idx_ext = IX_W'(idx_c);
	assign spill_c = (spill_inc && (spill_q != SPILL_MAX)) ? spill_q + SPILL_W'(1) : spill_q;

	// Control state: stage valids, used flags, spill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			used_q   <= '0;
			spill_q  <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				used_q  <= (used_q | set_vec) & ~clr_vec;
				spill_q <= spill_c;
			end
		end
	end

	// Payload: capture request, write new key, hold result
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= s_axis_tuser;
			key_s1 <= s_axis_tdata;
		end
		if (advance) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (set_vec[i]) begin
					slot_key_q[i] <= key_k;
				end
			end
			status_s2 <= status_c;
			slot_s2   <= idx_ext[SLOT_W-1:0];
			spill_s2  <= spill_c;
		end
	end

	// Drive the result stream
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = {(OUT_DATA_W - SLOT_W - SPILL_W)'(0), spill_s2, slot_s2};

endmodule

// ===== sim/slot_table_checker.sv =====
`timescale 1ns / 100ps

module slot_table_checker
	import asa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[15:0]
	input  logic [OP_W-1:0]       s_axis_tuser,   // op[1:0]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot_index[2:0], spill_total[34:3], zero pad
	input  logic [STATUS_W-1:0]   m_axis_tuser,   // status[2:0]
	output int                    fail_count,
	output int                    pending
);

	localparam int unsigned NUM_SLOTS = SLOTS_DEF;
	localparam int unsigned PAD_LSB   = SLOT_W + SPILL_W;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SPILL_W-1:0]  spill;
	} slot_result_t;

	// Shadow copy of the slot table
	logic [NUM_SLOTS-1:0] slot_busy;
	logic [KEY_W-1:0]     slot_tag [NUM_SLOTS];
	logic [SPILL_W-1:0]   spill_tally;
	slot_result_t         expected_results [$];

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Search the table, update it and queue the result one request causes
	task automatic apply_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		int hit;
		int free_slot;
		slot_result_t res;
		hit = -1;
		free_slot = -1;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hit < 0 && slot_busy[i] && slot_tag[i] == key)
				hit = i;
			if (free_slot < 0 && !slot_busy[i])
				free_slot = i;
		end
		res.status = ST_MISS;
		res.slot   = '0;
		case (op)
			OP_ALLOC: begin
				if (hit >= 0) begin
					res.status = ST_HELD;
					res.slot   = SLOT_W'(hit);
				end else if (free_slot >= 0) begin
					slot_busy[free_slot] = 1'b1;
					slot_tag[free_slot]  = key;
					res.status = ST_TAKEN;
					res.slot   = SLOT_W'(free_slot);
				end else if (spill_tally != SPILL_MAX) begin
					spill_tally++;
				end
			end
			OP_RELEASE: begin
				if (hit >= 0) begin
					slot_busy[hit] = 1'b0;
					res.status = ST_FREED;
					res.slot   = SLOT_W'(hit);
				end else begin
					res.status = ST_FREE_MISS;
				end
			end
			default: begin
				// look up, and the unused code behaves the same
				if (hit >= 0) begin
					res.status = ST_HELD;
					res.slot   = SLOT_W'(hit);
				end
			end
		endcase
		res.spill = spill_tally;
		expected_results.push_back(res);
	endtask

	// Compare one result transaction with the oldest expectation
	task automatic check_result();
		slot_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected, tdata %0h tuser %0h",
				m_axis_tdata, m_axis_tuser));
		end else begin
			want = expected_results.pop_front();
			if (m_axis_tuser !== want.status)
				report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
			if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
				report_mismatch($sformatf("slot_index got %0d want %0d",
					m_axis_tdata[SLOT_W-1:0], want.slot));
			if (m_axis_tdata[PAD_LSB-1:SLOT_W] !== want.spill)
				report_mismatch($sformatf("spill_total got %0d want %0d",
					m_axis_tdata[PAD_LSB-1:SLOT_W], want.spill));
			if (m_axis_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
				report_mismatch($sformatf("padding got %0h", m_axis_tdata[OUT_DATA_W-1:PAD_LSB]));
		end
	endtask

	// Watch both channels; results are checked before the new request is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy   = '0;
			spill_tally = '0;
			for (int i = 0; i < NUM_SLOTS; i++)
				slot_tag[i] = '0;
			expected_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready)
				apply_request(s_axis_tuser, s_axis_tdata[KEY_W-1:0]);
		end
		pending = expected_results.size();
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import asa_pkg::*;

	localparam int RANDOM_ITEMS   = 780;
	localparam int CALM_ITEMS     = 100;
	localparam int HOLD_OFF_AT    = 250;
	localparam int HOLD_OFF_LEN   = 200;
	localparam int DRAIN_CYCLES   = 10;
	localparam int IDLE_LIMIT     = 2000;
	localparam int POOL_SIZE      = 12;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key[15:0]
	logic [OP_W-1:0]       s_axis_tuser = '0;   // op[1:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // slot_index[2:0], spill_total[34:3], zero pad
	logic [STATUS_W-1:0]   m_axis_tuser;   // status[2:0]

	int fail_count;
	int pending;
	int sent = 0;
	bit calm = 1'b0;
	int idle_cycles = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	associative_slot_allocator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	slot_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #10 clk = ~clk;

	// Offer one request, with an optional idle burst first, and hold it until taken
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= key;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// Reset, stimulus and verdict
	initial begin
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		int pick;
		arst_n = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every search misses
		send_request(OP_LOOKUP, 16'h1234);
		send_request(OP_RELEASE, 16'h1234);
		send_request(OP_UNUSED, 16'h0000);
		// key extremes, repeat allocate and search hits
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_ALLOC, 16'hFFFF);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_LOOKUP, 16'hFFFF);
		send_request(OP_UNUSED, 16'hFFFF);
		// fill the table
		send_request(OP_ALLOC, 16'h5555);
		send_request(OP_ALLOC, 16'hAAAA);
		send_request(OP_ALLOC, 16'h0001);
		send_request(OP_ALLOC, 16'h8000);
		send_request(OP_ALLOC, 16'h00FF);
		send_request(OP_ALLOC, 16'hFF00);
		// full table spills
		send_request(OP_ALLOC, 16'h7FFF);
		send_request(OP_ALLOC, 16'hFFFE);
		// release in the middle, miss on a second release, refill lowest free
		send_request(OP_RELEASE, 16'h5555);
		send_request(OP_RELEASE, 16'h5555);
		send_request(OP_ALLOC, 16'h7FFF);
		send_request(OP_LOOKUP, 16'h7FFF);
		// free slot zero and search it
		send_request(OP_RELEASE, 16'h0000);
		send_request(OP_LOOKUP, 16'h0000);

		// mostly pooled keys so hits, fills and spills recur; some random noise keys
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = OP_ALLOC;
			else if (pick < 70)
				op = OP_RELEASE;
			else if (pick < 95)
				op = OP_LOOKUP;
			else
				op = OP_UNUSED;
			if ($urandom_range(0, 9) < 8)
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				key = KEY_W'($urandom);
			send_request(op, key);
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding results, then allow for the pipeline
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random ready/stall bursts, one long hold-off, steady ready at the end
	initial begin
		bit held_off;
		int burst;
		held_off = 1'b0;
		@(posedge clk);
		forever begin
			if (!held_off && sent >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(posedge clk);
			end else if (calm) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				burst = $urandom_range(1, 16);
				m_axis_tready <= ($urandom_range(0, 2) != 0);
				repeat (burst) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== filelist.f =====
rtl/core/asa_pkg.sv
rtl/core/associative_slot_allocator_top.sv
sim/slot_table_checker.sv
sim/testbench.sv
